[hw/rtl/pde_pkg.sv]
// Shared constants, types and codes of the postfix digit evaluator.
package pde_pkg;

  // Operand stack geometry.
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Queue between front and back; the depth must be a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Width of the divider step counter.
  localparam int unsigned DIV_CNT_W = $clog2(DATA_W + 1);

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_EQUALS  = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

  // Classified character kinds.
  typedef enum logic [3:0] {
    OP_DIGIT,
    OP_SPACE,
    OP_NEWLINE,
    OP_EQUALS,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_OTHER
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_DIVZERO   = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  // One classified character as it travels through the queue.
  typedef struct packed {
    op_e                op;
    logic [DIGIT_W-1:0] digit;
  } pde_item_t;

endpackage

[hw/rtl/pde_if.sv]
// Handshake interfaces for the character input and the result output.
interface pde_char_if import pde_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface pde_result_if import pde_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] answer;
  logic [1:0]               status;

  modport source (output valid, output answer, output status, input ready);
  modport sink (input valid, input answer, input status, output ready);
endinterface

[hw/rtl/postfix_digit_evaluator.sv]
// Top level of the postfix digit evaluator.
//
// Input channel char_i carries one ASCII character per transfer. Digits
// push 0..9 onto a 16-entry operand stack, spaces are dropped, '=' and
// newline end an expression, and every other character is an operator.
// Output channel result_o carries one result per finished expression or
// error: answer and status (0 ok, 1 malformed, 2 divide by zero, 3 stack
// overflow); answer is 0 whenever status is not 0. After a result the
// stack is cleared and the rest of the line is discarded.
// A front stage classifies characters into a 2-entry queue; the back
// stage executes them. Digits sustain one character per cycle while the
// back stage is idle; + - * and unknown operators pass through S_EXEC
// (registered stack read), and '/' then waits in S_DIV on the
// one-bit-per-cycle iterative divider. The result register loads when the
// back stage takes the ending item, or in S_EXEC for a division by zero.
// Reset clears the stack count, the discard flag, the queue and the
// result valid flag; no clearing pass is needed. If the receiver stalls,
// the result stays in the output register, characters that cause no
// result keep being executed, and the next result-producing character
// waits in the queue (in S_EXEC for a zero divisor) until the output frees.
module postfix_digit_evaluator import pde_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  pde_char_if.sink      char_i,
  pde_result_if.source  result_o
);

  logic      q_push_valid, q_push_ready;
  pde_item_t q_push_item;
  logic      q_pop_valid, q_pop_ready;
  pde_item_t q_pop_item;

  pde_front u_front (
    .char_i       (char_i),
    .push_valid_o (q_push_valid),
    .push_item_o  (q_push_item),
    .push_ready_i (q_push_ready)
  );

  pde_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_item_i  (q_push_item),
    .push_ready_o (q_push_ready),
    .pop_valid_o  (q_pop_valid),
    .pop_item_o   (q_pop_item),
    .pop_ready_i  (q_pop_ready)
  );

  pde_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_pop_valid),
    .item_i       (q_pop_item),
    .item_ready_o (q_pop_ready),
    .res_o        (result_o)
  );

endmodule

[hw/rtl/pde_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pde_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/pde_front.sv]
// Front part: accepts characters and classifies them into queue items.
module pde_front import pde_pkg::*; (
  pde_char_if.sink  char_i,
  output logic      push_valid_o,
  output pde_item_t push_item_o,
  input  logic      push_ready_i
);

  pde_item_t item;

  // Decode the character into an operation kind and a digit value.
  always_comb begin
    item.digit = char_i.char_in[DIGIT_W-1:0] - CH_ZERO[DIGIT_W-1:0];
    priority if (char_i.char_in >= CH_ZERO && char_i.char_in <= CH_NINE) begin
      item.op = OP_DIGIT;
    end else if (char_i.char_in == CH_SPACE) begin
      item.op = OP_SPACE;
    end else if (char_i.char_in == CH_NEWLINE) begin
      item.op = OP_NEWLINE;
    end else if (char_i.char_in == CH_EQUALS) begin
      item.op = OP_EQUALS;
    end else if (char_i.char_in == CH_PLUS) begin
      item.op = OP_ADD;
    end else if (char_i.char_in == CH_MINUS) begin
      item.op = OP_SUB;
    end else if (char_i.char_in == CH_STAR) begin
      item.op = OP_MUL;
    end else if (char_i.char_in == CH_SLASH) begin
      item.op = OP_DIV;
    end else begin
      item.op = OP_OTHER;
    end
  end

  // Spaces never change the evaluator state, so they are dropped here.
  assign char_i.ready  = push_ready_i || (item.op == OP_SPACE);
  assign push_valid_o  = char_i.valid && (item.op != OP_SPACE);
  assign push_item_o   = item;

endmodule

[hw/rtl/pde_queue.sv]
// Short FIFO that decouples the classifying front from the executing back.
module pde_queue import pde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  input  pde_item_t push_item_i,
  output logic      push_ready_o,
  output logic      pop_valid_o,
  output pde_item_t pop_item_o,
  input  logic      pop_ready_i
);

  pde_item_t           slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_q, wptr_d;
  logic [QUEUE_AW-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0]   fill_q, fill_d;
  logic                push, pop;

  assign push_ready_o = (fill_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_item_o   = slot_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping; pointers wrap naturally.
  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    fill_d = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // Item storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_item_i;
    end
  end

endmodule

[hw/rtl/pde_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module pde_div import pde_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 neg_q, neg_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [DATA_W-1:0]    mag_q, mag_d;
  logic [DATA_W:0]      trial;

  // Restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, mag_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    mag_d  = mag_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DATA_W);
      neg_d  = dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      rem_d  = '0;
      quo_d  = dividend_i[DATA_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      mag_d  = divisor_i[DATA_W-1] ? (~divisor_i + 1'b1) : divisor_i;
    end else if (busy_q) begin
      if (!trial[DATA_W]) begin
        rem_d = trial[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    mag_q <= mag_d;
  end

  // Apply the sign on the way out.
  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

[hw/rtl/pde_back.sv]
// Back part: operand stack, arithmetic, line discarding and the result register.
module pde_back import pde_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_valid_i,
  input  pde_item_t     item_i,
  output logic          item_ready_o,
  pde_result_if.source  res_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DIV  = 3'b100
  } state_e;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     skip_q, skip_d;
  op_e                      op_q, op_d;
  logic [DATA_W-1:0]        tos_q, tos_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_answer_q, out_answer_d;
  status_e                  out_status_q, out_status_d;

  logic              can_emit;
  logic              emit;
  status_e           emit_status;
  logic [DATA_W-1:0] emit_value;
  logic              ram_we, ram_re;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic [DATA_W-1:0] left, right;
  logic              div_start, div_done;
  logic [DATA_W-1:0] div_quo;

  // Entries below the top live in the RAM; the top is kept in tos_q.
  pde_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_m1[ADDR_W-1:0]),
    .wdata_i (tos_q),
    .re_i    (ram_re),
    .raddr_i (cnt_m2[ADDR_W-1:0]),
    .rdata_o (left)
  );

  pde_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (left),
    .divisor_i  (right),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign cnt_m1   = count_q - 1'b1;
  assign cnt_m2   = count_q - CNT_W'(2);
  assign right    = tos_q;
  assign can_emit = !out_valid_q || res_o.ready;

  // Sequencer for one queue item at a time.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    skip_d       = skip_q;
    op_d         = op_q;
    tos_d        = tos_q;
    item_ready_o = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    div_start    = 1'b0;
    emit         = 1'b0;
    emit_status  = ST_OK;
    emit_value   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          if (skip_q) begin
            // Discard up to and including the next newline.
            item_ready_o = 1'b1;
            if (item_i.op == OP_NEWLINE) begin
              skip_d = 1'b0;
            end
          end else begin
            unique case (item_i.op)
              OP_DIGIT: begin
                if (count_q == CNT_W'(STACK_DEPTH)) begin
                  if (can_emit) begin
                    item_ready_o = 1'b1;
                    emit         = 1'b1;
                    emit_status  = ST_OVERFLOW;
                    count_d      = '0;
                    skip_d       = 1'b1;
                  end
                end else begin
                  item_ready_o = 1'b1;
                  ram_we       = (count_q != '0);
                  tos_d        = DATA_W'(item_i.digit);
                  count_d      = count_q + 1'b1;
                end
              end
              OP_SPACE: begin
                item_ready_o = 1'b1;
              end
              OP_NEWLINE: begin
                if (can_emit) begin
                  item_ready_o = 1'b1;
                  emit         = 1'b1;
                  emit_status  = ST_MALFORMED;
                  count_d      = '0;
                  skip_d       = 1'b0;
                end
              end
              OP_EQUALS: begin
                if (can_emit) begin
                  item_ready_o = 1'b1;
                  emit         = 1'b1;
                  if (count_q == CNT_W'(1)) begin
                    emit_status = ST_OK;
                    emit_value  = tos_q;
                  end else begin
                    emit_status = ST_MALFORMED;
                  end
                  count_d = '0;
                  skip_d  = 1'b1;
                end
              end
              default: begin
                // Operators, known or not, need two operands.
                if (count_q < CNT_W'(2)) begin
                  if (can_emit) begin
                    item_ready_o = 1'b1;
                    emit         = 1'b1;
                    emit_status  = ST_MALFORMED;
                    count_d      = '0;
                    skip_d       = 1'b1;
                  end
                end else begin
                  item_ready_o = 1'b1;
                  ram_re       = 1'b1;
                  op_d         = item_i.op;
                  state_d      = S_EXEC;
                end
              end
            endcase
          end
        end
      end
      S_EXEC: begin
        // Left operand is now on the RAM read port.
        unique case (op_q)
          OP_ADD: begin
            tos_d   = left + right;
            count_d = cnt_m1;
            state_d = S_IDLE;
          end
          OP_SUB: begin
            tos_d   = left - right;
            count_d = cnt_m1;
            state_d = S_IDLE;
          end
          OP_MUL: begin
            tos_d   = left * right;
            count_d = cnt_m1;
            state_d = S_IDLE;
          end
          OP_DIV: begin
            if (right == '0) begin
              if (can_emit) begin
                emit        = 1'b1;
                emit_status = ST_DIVZERO;
                count_d     = '0;
                skip_d      = 1'b1;
                state_d     = S_IDLE;
              end
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          default: begin
            // Unknown operator leaves the left operand in place.
            tos_d   = left;
            count_d = cnt_m1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          tos_d   = div_quo;
          count_d = cnt_m1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register: a new result loads when the old one is taken or absent.
  always_comb begin
    out_valid_d  = out_valid_q && !res_o.ready;
    out_answer_d = out_answer_q;
    out_status_d = out_status_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_answer_d = (emit_status == ST_OK) ? emit_value : '0;
      out_status_d = emit_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    tos_q        <= tos_d;
    out_answer_q <= out_answer_d;
    out_status_q <= out_status_d;
  end

  assign res_o.valid  = out_valid_q;
  assign res_o.answer = out_answer_q;
  assign res_o.status = out_status_q;

endmodule
